// ===== rtl/sha5_pkg.sv =====
// Package with SHA-512 constants, round table, IV and mixing functions.
`timescale 1ns / 1ps
package sha5_pkg;

    localparam logic [63:0] IV_XOR_MASK = 64'ha5a5a5a5a5a5a5a5;
    localparam logic [7:0]  PAD_BYTE    = 8'h80;
    localparam logic [7:0]  LEN_OFFSET  = 8'd112;
    localparam logic [7:0]  BLOCK_BYTES = 8'd128;
    localparam logic [6:0]  LAST_ROUND  = 7'd79;

    function automatic logic [63:0] round_k(input logic [6:0] t);
        logic [63:0] k;
        case (t)
            7'd0:  k = 64'h428a2f98d728ae22;  7'd1:  k = 64'h7137449123ef65cd;
            7'd2:  k = 64'hb5c0fbcfec4d3b2f;  7'd3:  k = 64'he9b5dba58189dbbc;
            7'd4:  k = 64'h3956c25bf348b538;  7'd5:  k = 64'h59f111f1b605d019;
            7'd6:  k = 64'h923f82a4af194f9b;  7'd7:  k = 64'hab1c5ed5da6d8118;
            7'd8:  k = 64'hd807aa98a3030242;  7'd9:  k = 64'h12835b0145706fbe;
            7'd10: k = 64'h243185be4ee4b28c;  7'd11: k = 64'h550c7dc3d5ffb4e2;
            7'd12: k = 64'h72be5d74f27b896f;  7'd13: k = 64'h80deb1fe3b1696b1;
            7'd14: k = 64'h9bdc06a725c71235;  7'd15: k = 64'hc19bf174cf692694;
            7'd16: k = 64'he49b69c19ef14ad2;  7'd17: k = 64'hefbe4786384f25e3;
            7'd18: k = 64'h0fc19dc68b8cd5b5;  7'd19: k = 64'h240ca1cc77ac9c65;
            7'd20: k = 64'h2de92c6f592b0275;  7'd21: k = 64'h4a7484aa6ea6e483;
            7'd22: k = 64'h5cb0a9dcbd41fbd4;  7'd23: k = 64'h76f988da831153b5;
            7'd24: k = 64'h983e5152ee66dfab;  7'd25: k = 64'ha831c66d2db43210;
            7'd26: k = 64'hb00327c898fb213f;  7'd27: k = 64'hbf597fc7beef0ee4;
            7'd28: k = 64'hc6e00bf33da88fc2;  7'd29: k = 64'hd5a79147930aa725;
            7'd30: k = 64'h06ca6351e003826f;  7'd31: k = 64'h142929670a0e6e70;
            7'd32: k = 64'h27b70a8546d22ffc;  7'd33: k = 64'h2e1b21385c26c926;
            7'd34: k = 64'h4d2c6dfc5ac42aed;  7'd35: k = 64'h53380d139d95b3df;
            7'd36: k = 64'h650a73548baf63de;  7'd37: k = 64'h766a0abb3c77b2a8;
            7'd38: k = 64'h81c2c92e47edaee6;  7'd39: k = 64'h92722c851482353b;
            7'd40: k = 64'ha2bfe8a14cf10364;  7'd41: k = 64'ha81a664bbc423001;
            7'd42: k = 64'hc24b8b70d0f89791;  7'd43: k = 64'hc76c51a30654be30;
            7'd44: k = 64'hd192e819d6ef5218;  7'd45: k = 64'hd69906245565a910;
            7'd46: k = 64'hf40e35855771202a;  7'd47: k = 64'h106aa07032bbd1b8;
            7'd48: k = 64'h19a4c116b8d2d0c8;  7'd49: k = 64'h1e376c085141ab53;
            7'd50: k = 64'h2748774cdf8eeb99;  7'd51: k = 64'h34b0bcb5e19b48a8;
            7'd52: k = 64'h391c0cb3c5c95a63;  7'd53: k = 64'h4ed8aa4ae3418acb;
            7'd54: k = 64'h5b9cca4f7763e373;  7'd55: k = 64'h682e6ff3d6b2b8a3;
            7'd56: k = 64'h748f82ee5defb2fc;  7'd57: k = 64'h78a5636f43172f60;
            7'd58: k = 64'h84c87814a1f0ab72;  7'd59: k = 64'h8cc702081a6439ec;
            7'd60: k = 64'h90befffa23631e28;  7'd61: k = 64'ha4506cebde82bde9;
            7'd62: k = 64'hbef9a3f7b2c67915;  7'd63: k = 64'hc67178f2e372532b;
            7'd64: k = 64'hca273eceea26619c;  7'd65: k = 64'hd186b8c721c0c207;
            7'd66: k = 64'heada7dd6cde0eb1e;  7'd67: k = 64'hf57d4f7fee6ed178;
            7'd68: k = 64'h06f067aa72176fba;  7'd69: k = 64'h0a637dc5a2c898a6;
            7'd70: k = 64'h113f9804bef90dae;  7'd71: k = 64'h1b710b35131c471b;
            7'd72: k = 64'h28db77f523047d84;  7'd73: k = 64'h32caab7b40c72493;
            7'd74: k = 64'h3c9ebe0a15c9bebc;  7'd75: k = 64'h431d67c49c100d4c;
            7'd76: k = 64'h4cc5d4becb3e42b6;  7'd77: k = 64'h597f299cfc657e2a;
            7'd78: k = 64'h5fcb6fab3ad6faec;  7'd79: k = 64'h6c44198c4a475817;
            default: k = 64'h0;
        endcase
        return k;
    endfunction

    function automatic logic [63:0] std_iv(input logic [2:0] i);
        logic [63:0] v;
        case (i)
            3'd0: v = 64'h6a09e667f3bcc908;
            3'd1: v = 64'hbb67ae8584caa73b;
            3'd2: v = 64'h3c6ef372fe94f82b;
            3'd3: v = 64'ha54ff53a5f1d36f1;
            3'd4: v = 64'h510e527fade682d1;
            3'd5: v = 64'h9b05688c2b3e6c1f;
            3'd6: v = 64'h1f83d9abfb41bd6b;
            3'd7: v = 64'h5be0cd19137e2179;
            default: v = 64'h0;
        endcase
        return v;
    endfunction

    function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
        return (x >> n) | (x << (64 - n));
    endfunction

endpackage

// ===== rtl/sha5_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module sha5_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/sha512_hash_engine_top.sv =====
// SHA-512 engine top: byte packing, padding, 80-round compression, digest output.
// A non-last item passes through S_HI (length carry) and S_PUSH (byte packing); a full
// block then runs 2 schedule loads, 80 rounds at one per cycle, and 1 chain add.
// Last item: padding plus one or two compressions, then 8 digest items.
// No new input item is taken until the engine is back in S_IDLE; o_stall is high meanwhile.
// Reset (synchronous, active low): iv_mode 0, standard IV, counts cleared, idle.
`timescale 1ns / 1ps
module sha512_hash_engine_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [63:0] i_data_word,
    input  logic [3:0]  i_byte_count,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word,
    output logic        o_length_error
);
    import sha5_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_HI, S_PUSH, S_LOAD0, S_LOAD1, S_ROUND, S_FINAL, S_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_DATA, PH_PAD, PH_ZERO, PH_LHI, PH_LLO
    } t_phase;

    t_state      r_state;
    t_phase      r_phase;
    logic        r_iv_mode;
    logic [63:0] r_h [8];
    logic [63:0] r_v [8];
    logic [63:0] r_wt;
    logic [63:0] r_hist [15];
    logic [6:0]  r_t;
    logic [63:0] r_in;
    logic [3:0]  r_rem;
    logic        r_last;
    logic [63:0] r_acc;
    logic [7:0]  r_fill;
    logic [63:0] r_len_lo;
    logic [63:0] r_len_hi;
    logic        r_carry;
    logic        r_ovf;
    logic [2:0]  r_oidx;

    logic        in_acc;
    logic [3:0]  n_clamp;
    logic [64:0] n_lo_sum;
    logic [2:0]  off;
    logic [3:0]  room;
    logic [3:0]  k;
    logic [63:0] src;
    logic [63:0] mask;
    logic [63:0] acc_new;
    logic [7:0]  fill_new;
    logic        word_done;
    logic        ram_we;
    logic [3:0]  ram_raddr;
    logic [63:0] ram_rdata;
    logic [63:0] t1;
    logic [63:0] t2;
    logic [63:0] w_next;
    logic [6:0]  t_next;

    assign in_acc  = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);
    assign n_clamp = (i_byte_count > 4'd8) ? 4'd8 : i_byte_count;
    assign n_lo_sum = {1'b0, r_len_lo} + {58'd0, n_clamp, 3'b000};

    // Byte packing into the current block word.
    assign off  = r_fill[2:0];
    assign room = 4'd8 - {1'b0, off};
    always_comb begin
        if (r_phase == PH_ZERO) begin
            k   = room;
            src = 64'd0;
        end else begin
            k   = (r_rem < room) ? r_rem : room;
            src = r_in;
        end
    end
    assign mask     = ({64{1'b1}} << (7'd64 - {k, 3'b000})) >> {off, 3'b000};
    assign acc_new  = (r_acc & ~mask) | ((src >> {off, 3'b000}) & mask);
    assign fill_new = r_fill + {4'd0, k};
    assign word_done = (k == room) && (k != 4'd0);
    assign ram_we   = (r_state == S_PUSH) && word_done &&
                      !(r_phase == PH_ZERO && r_fill == LEN_OFFSET) &&
                      !(r_phase != PH_ZERO && r_rem == 4'd0);

    always_comb begin
        case (r_state)
            S_LOAD0: ram_raddr = 4'd0;
            S_LOAD1: ram_raddr = 4'd1;
            default: ram_raddr = 4'(r_t + 7'd2);
        endcase
    end

    sha5_ram #(.WIDTH(64), .DEPTH(16)) u_block (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_fill[6:3]),
        .i_wdata (acc_new),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Round function and message schedule.
    assign t1 = r_v[7] + (rotr(r_v[4], 14) ^ rotr(r_v[4], 18) ^ rotr(r_v[4], 41))
              + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6])) + round_k(r_t) + r_wt;
    assign t2 = (rotr(r_v[0], 28) ^ rotr(r_v[0], 34) ^ rotr(r_v[0], 39))
              + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    assign w_next = (rotr(r_hist[0], 19) ^ rotr(r_hist[0], 61) ^ (r_hist[0] >> 6))
                  + r_hist[5]
                  + (rotr(r_hist[13], 1) ^ rotr(r_hist[13], 8) ^ (r_hist[13] >> 7))
                  + r_hist[14];
    assign t_next = r_t + 7'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_phase   <= PH_DATA;
            r_iv_mode <= 1'b0;
            r_fill    <= 8'd0;
            r_len_lo  <= 64'd0;
            r_len_hi  <= 64'd0;
            r_ovf     <= 1'b0;
            r_carry   <= 1'b0;
            r_oidx    <= 3'd0;
            r_t       <= 7'd0;
            r_rem     <= 4'd0;
            r_last    <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= std_iv(3'(i));
        end else if (i_cfg_we) begin
            r_iv_mode <= i_cfg_wdata;
            r_state   <= S_IDLE;
            r_fill    <= 8'd0;
            r_len_lo  <= 64'd0;
            r_len_hi  <= 64'd0;
            r_ovf     <= 1'b0;
            for (int i = 0; i < 8; i++)
                r_h[i] <= i_cfg_wdata ? (std_iv(3'(i)) ^ IV_XOR_MASK) : std_iv(3'(i));
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_in     <= i_data_word;
                        r_rem    <= n_clamp;
                        r_last   <= i_last;
                        r_len_lo <= n_lo_sum[63:0];
                        r_carry  <= n_lo_sum[64];
                        r_state  <= S_HI;
                    end
                end
                S_HI: begin
                    if (r_carry) begin
                        r_len_hi <= r_len_hi + 64'd1;
                        if (r_len_hi == {64{1'b1}}) r_ovf <= 1'b1;
                    end
                    r_phase <= PH_DATA;
                    r_state <= S_PUSH;
                end
                S_PUSH: begin
                    if (r_phase == PH_ZERO && r_fill == LEN_OFFSET) begin
                        r_phase <= PH_LHI;
                        r_in    <= r_len_hi;
                        r_rem   <= 4'd8;
                    end else if (r_phase != PH_ZERO && r_rem == 4'd0) begin
                        case (r_phase)
                            PH_DATA: begin
                                if (r_last) begin
                                    r_phase <= PH_PAD;
                                    r_in    <= {PAD_BYTE, 56'd0};
                                    r_rem   <= 4'd1;
                                end else begin
                                    r_state <= S_IDLE;
                                end
                            end
                            PH_PAD: r_phase <= PH_ZERO;
                            PH_LHI: begin
                                r_phase <= PH_LLO;
                                r_in    <= r_len_lo;
                                r_rem   <= 4'd8;
                            end
                            default: begin
                                r_oidx  <= 3'd0;
                                r_state <= S_OUT;
                            end
                        endcase
                    end else begin
                        r_acc <= acc_new;
                        r_in  <= r_in << {k, 3'b000};
                        r_rem <= r_rem - k;
                        if (fill_new == BLOCK_BYTES) begin
                            r_fill  <= 8'd0;
                            r_state <= S_LOAD0;
                        end else begin
                            r_fill <= fill_new;
                        end
                    end
                end
                S_LOAD0: r_state <= S_LOAD1;
                S_LOAD1: begin
                    r_wt <= ram_rdata;
                    r_t  <= 7'd0;
                    for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
                    r_state <= S_ROUND;
                end
                S_ROUND: begin
                    r_v[7] <= r_v[6];
                    r_v[6] <= r_v[5];
                    r_v[5] <= r_v[4];
                    r_v[4] <= r_v[3] + t1;
                    r_v[3] <= r_v[2];
                    r_v[2] <= r_v[1];
                    r_v[1] <= r_v[0];
                    r_v[0] <= t1 + t2;
                    r_hist[0] <= r_wt;
                    for (int i = 1; i < 15; i++) r_hist[i] <= r_hist[i-1];
                    r_wt <= (t_next < 7'd16) ? ram_rdata : w_next;
                    r_t  <= t_next;
                    if (r_t == LAST_ROUND) r_state <= S_FINAL;
                end
                S_FINAL: begin
                    for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
                    r_state <= S_PUSH;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        if (r_oidx == 3'd7) begin
                            r_state  <= S_IDLE;
                            r_fill   <= 8'd0;
                            r_len_lo <= 64'd0;
                            r_len_hi <= 64'd0;
                            r_ovf    <= 1'b0;
                            for (int i = 0; i < 8; i++)
                                r_h[i] <= r_iv_mode ? (std_iv(3'(i)) ^ IV_XOR_MASK)
                                                    : std_iv(3'(i));
                        end else begin
                            r_oidx <= r_oidx + 3'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid        = (r_state == S_OUT);
    assign o_digest_word  = r_h[r_oidx];
    assign o_word_index   = r_oidx;
    assign o_last_word    = (r_oidx == 3'd7);
    assign o_length_error = r_ovf;

    a_out_block_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_fill == 8'd0))
        else $error("digest shown with a partly filled block");

    a_no_write_in_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND || r_state == S_LOAD0 || r_state == S_LOAD1) |-> !ram_we)
        else $error("block write during compression");

    a_last_ends_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_stall && o_last_word && !i_cfg_we) |=> !o_valid)
        else $error("digest output ran past the last item");

    a_round_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROUND) |-> (r_t <= LAST_ROUND))
        else $error("round counter out of range");
endmodule

// ===== dv/sha512_hash_engine_top_tb.sv =====
// Self-checking testbench for the SHA-512 hash engine: directed and random messages, digest prediction.
`timescale 1ns / 1ps
module sha512_hash_engine_top_tb;
    import sha5_pkg::*;

    typedef struct packed {
        logic [63:0] data;
        logic [3:0]  nbytes;
        logic        last;
    } t_msg_item;

    typedef struct packed {
        logic [63:0] word;
        logic [2:0]  index;
        logic        final_word;
        logic        len_err;
    } t_digest_item;

    localparam int LIMIT_CYCLES = 1500000;
    localparam int HOLD_LEN     = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_wdata = 1'b0;
    logic        i_valid = 1'b0;
    logic [63:0] i_data_word = '0;
    logic [3:0]  i_byte_count = '0;
    logic        i_last = 1'b0;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [63:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;
    logic        o_length_error;

    sha512_hash_engine_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_data_word(i_data_word), .i_byte_count(i_byte_count), .i_last(i_last),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_digest_word(o_digest_word), .o_word_index(o_word_index),
        .o_last_word(o_last_word), .o_length_error(o_length_error)
    );

    always #5 i_clk = ~i_clk;

    // shadow hash state
    logic        mdl_iv_sel;
    logic [63:0] mdl_chain [8];
    logic [7:0]  mdl_block [128];
    int          mdl_fill;
    logic [127:0] mdl_bits;
    logic        mdl_ovf;

    t_msg_item    pending_q [$];
    t_digest_item digest_q [$];
    int  mismatches = 0;
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic hold_go = 1'b0;
    logic hold_armed = 1'b0;
    int  hold_cycles = 0;
    longint cycle_count = 0;

    function automatic logic [63:0] ror64(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    task automatic compress_block();
        logic [63:0] w [80];
        logic [63:0] v [8];
        logic [63:0] s0, s1, t1, t2;
        for (int t = 0; t < 16; t++)
            for (int b = 0; b < 8; b++) w[t][63-8*b -: 8] = mdl_block[8*t+b];
        for (int t = 16; t < 80; t++) begin
            s0 = ror64(w[t-15], 1) ^ ror64(w[t-15], 8) ^ (w[t-15] >> 7);
            s1 = ror64(w[t-2], 19) ^ ror64(w[t-2], 61) ^ (w[t-2] >> 6);
            w[t] = s1 + w[t-7] + s0 + w[t-16];
        end
        for (int i = 0; i < 8; i++) v[i] = mdl_chain[i];
        for (int t = 0; t < 80; t++) begin
            t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + round_k(7'(t)) + w[t];
            t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) mdl_chain[i] += v[i];
    endtask

    task automatic add_byte(logic [7:0] b);
        mdl_block[mdl_fill] = b;
        mdl_fill++;
        if (mdl_fill == 128) begin
            compress_block();
            mdl_fill = 0;
        end
    endtask

    task automatic restart_message();
        for (int i = 0; i < 8; i++)
            mdl_chain[i] = mdl_iv_sel ? std_iv(3'(i)) ^ IV_XOR_MASK : std_iv(3'(i));
        mdl_fill = 0;
        mdl_bits = '0;
        mdl_ovf = 1'b0;
    endtask

    task automatic hash_word(t_msg_item it);
        int n;
        logic [127:0] sum;
        logic [127:0] len;
        logic err;
        t_digest_item d;
        n = (it.nbytes > 8) ? 8 : int'(it.nbytes);
        for (int i = 0; i < n; i++) add_byte(it.data[63-8*i -: 8]);
        sum = mdl_bits + 128'(n * 8);
        if (sum < mdl_bits) mdl_ovf = 1'b1;
        mdl_bits = sum;
        if (!it.last) return;
        len = mdl_bits;
        err = mdl_ovf;
        add_byte(8'h80);
        while (mdl_fill != 112) add_byte(8'h00);
        for (int i = 0; i < 16; i++) add_byte(len[127-8*i -: 8]);
        for (int i = 0; i < 8; i++) begin
            d.word = mdl_chain[i];
            d.index = 3'(i);
            d.final_word = (i == 7);
            d.len_err = err;
            digest_q.push_back(d);
        end
        restart_message();
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!(i_valid && o_stall)) begin
                if (pending_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    t_msg_item it;
                    it = pending_q.pop_front();
                    i_valid <= 1'b1;
                    i_data_word <= it.data;
                    i_byte_count <= it.nbytes;
                    i_last <= it.last;
                    hash_word(it);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall, with one long hold
    always @(posedge i_clk) begin
        if (hold_go && !hold_armed) begin
            hold_armed <= 1'b1;
            hold_cycles <= HOLD_LEN;
            i_stall <= 1'b1;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    // monitor and cycle limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_valid && !i_stall) begin
            if (digest_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected digest item %h", o_digest_word);
            end else begin
                t_digest_item e;
                e = digest_q.pop_front();
                if (e != {o_digest_word, o_word_index, o_last_word, o_length_error}) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp %h/%0d/%0b/%0b got %h/%0d/%0b/%0b",
                            e.word, e.index, e.final_word, e.len_err, o_digest_word,
                            o_word_index, o_last_word, o_length_error);
                end
            end
        end
        if (cycle_count > LIMIT_CYCLES) begin
            $display("** sha512_hash_engine_top: FAILED **");
            $finish;
        end
    end

    function automatic t_msg_item mk(logic [63:0] d, logic [3:0] n, logic l);
        t_msg_item it;
        it.data = d; it.nbytes = n; it.last = l;
        return it;
    endfunction

    function automatic logic [63:0] rnd64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic queue_message(int nwords);
        for (int i = 0; i < nwords - 1; i++)
            pending_q.push_back(mk(rnd64(), ($urandom_range(9, 0) == 0) ?
                4'($urandom_range(15, 0)) : 4'd8, 1'b0));
        pending_q.push_back(mk(rnd64(), 4'($urandom_range(15, 0)), 1'b1));
    endtask

    task automatic drain();
        while (pending_q.size() > 0 || i_valid || digest_q.size() > 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    task automatic write_iv_mode(logic m);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mdl_iv_sel = m;
        restart_message();
    endtask

    task automatic run_phase(int idle, int stall, int nitems);
        int sent;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        sent = 0;
        while (sent < nitems) begin
            int w;
            w = $urandom_range(40, 1);
            if ($urandom_range(3, 0) == 0) w = $urandom_range(3, 1);
            queue_message(w);
            sent += w;
        end
        drain();
    endtask

    initial begin
        mdl_iv_sel = 1'b0;
        restart_message();
        for (int i = 0; i < 128; i++) mdl_block[i] = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: empty, all-ones/zeros, short words, oversize count, zero-count words
        pending_q.push_back(mk(64'h0, 4'd0, 1'b1));
        pending_q.push_back(mk('1, 4'd8, 1'b1));
        pending_q.push_back(mk(64'h6162630000000000, 4'd3, 1'b1));
        pending_q.push_back(mk('1, 4'd15, 1'b0));
        pending_q.push_back(mk('1, 4'd0, 1'b0));
        pending_q.push_back(mk(64'h0, 4'd9, 1'b1));
        for (int i = 0; i < 14; i++) pending_q.push_back(mk(rnd64(), 4'd8, 1'b0));
        pending_q.push_back(mk(64'h0123456789abcdef, 4'd7, 1'b1));
        pending_q.push_back(mk(rnd64(), 4'd1, 1'b1));
        drain();
        write_iv_mode(1'b1);
        pending_q.push_back(mk(rnd64(), 4'd5, 1'b1));
        drain();

        // back-pressure: long receiver hold while the sender keeps offering
        hold_go = 1'b1;
        queue_message(20);
        queue_message(4);
        drain();

        write_iv_mode(1'b0);
        run_phase(0, 0, 35);
        run_phase(74, 0, 30);
        write_iv_mode(1'b1);
        run_phase(0, 74, 30);
        // abandon a partial message with a mode write
        pending_q.push_back(mk(rnd64(), 4'd8, 1'b0));
        pending_q.push_back(mk(rnd64(), 4'd3, 1'b0));
        drain();
        write_iv_mode(1'b0);
        run_phase(17, 17, 35);

        if (mismatches == 0 && digest_q.size() == 0) begin
            $display("** sha512_hash_engine_top: PASSED **");
        end else begin
            $display("** sha512_hash_engine_top: FAILED **");
        end
        $finish;
    end
endmodule
